// ===== src/spqi_pkg.sv =====
// types and constants shared by the sorted job queue
`default_nettype none
package spqi_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [3:0]  position;
		logic [2:0]  priority_req;
		logic [7:0]  owner_tag;
		logic [10:0] time_minutes;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        full_flag;
		logic [2:0]  entry_priority;
		logic [7:0]  entry_owner;
		logic [10:0] entry_time;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  prio;
		logic [7:0]  owner;
		logic [10:0] tod;
	} entry_t;

	// what one cell shows its successor and the read mux
	typedef struct packed {
		entry_t entry;
		logic   valid;
		logic   gt;
	} cell_out_t;

endpackage
`default_nettype wire

// ===== src/spqi_cell.sv =====
// one queue slot: holds an entry, takes the new job or its neighbor's entry on insert
`default_nettype none
module spqi_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  ins,
	input  spqi_pkg::entry_t     new_entry,
	input  spqi_pkg::cell_out_t  prev,
	output spqi_pkg::cell_out_t  cur
);
	import spqi_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   gt;

	// the new job goes in front of an empty slot or a strictly larger priority
	assign gt = !valid_q || (entry_q.prio > new_entry.prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins && gt) begin
			valid_q <= prev.gt ? prev.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && gt) begin
			entry_q <= prev.gt ? prev.entry : new_entry;
		end
	end

	assign cur.entry = entry_q;
	assign cur.valid = valid_q;
	assign cur.gt    = gt;

endmodule
`default_nettype wire

// ===== src/stable_priority_queue_insert_top.sv =====
// sorted job queue: row of slot cells, read mux and registered result
//
// channel   direction  handshake               payload
// request   in         start & !busy           req  (spqi_pkg::req_t)
// result    out        done, one cycle         rsp  (spqi_pkg::rsp_t)
//
// one transaction per cycle: all cells compare the new priority in parallel
// and shift in the same edge, so busy stays low.
// the result appears with done in the cycle after the transaction is taken.
// reset empties the queue at once (valid bits and count); slot data is not cleared.
// the receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none
module stable_priority_queue_insert_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  spqi_pkg::req_t   req,
	output logic             done,
	output spqi_pkg::rsp_t   rsp
);
	import spqi_pkg::*;

	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CMPW = (CW > 4) ? CW : 4;

	cell_out_t        cells [QUEUE_DEPTH];
	cell_out_t        head_in;
	entry_t           new_entry;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic             take;
	logic             full;
	logic             do_ins;
	logic             rd_hit;
	logic [CMPW-1:0]  pos_w;
	logic [IW-1:0]    rd_idx;
	rsp_t             rsp_nxt;
	rsp_t             rsp_q;
	logic             done_q;

	assign busy = 1'b0;
	assign take = start && !busy;
	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign do_ins = take && (req.kind == KIND_INSERT) && !full;

	assign new_entry.prio  = req.priority_req;
	assign new_entry.owner = req.owner_tag;
	assign new_entry.tod   = req.time_minutes;

	// nothing ahead of the head cell
	assign head_in.entry = new_entry;
	assign head_in.valid = 1'b0;
	assign head_in.gt    = 1'b0;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			spqi_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (do_ins),
				.new_entry (new_entry),
				.prev      (head_in),
				.cur       (cells[g])
			);
		end else begin : g_body
			spqi_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (do_ins),
				.new_entry (new_entry),
				.prev      (cells[g-1]),
				.cur       (cells[g])
			);
		end
	end

	assign count_nxt = do_ins ? (count_q + CW'(1)) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign pos_w  = CMPW'(req.position);
	assign rd_idx = pos_w[IW-1:0];
	assign rd_hit = (pos_w < CMPW'(count_q));

	always_comb begin
		rsp_nxt           = '0;
		rsp_nxt.occupancy = 5'(count_nxt);
		if (req.kind == KIND_INSERT) begin
			rsp_nxt.accepted  = !full;
			rsp_nxt.full_flag = full;
		end else if (rd_hit) begin
			rsp_nxt.accepted       = 1'b1;
			rsp_nxt.entry_priority = cells[rd_idx].entry.prio;
			rsp_nxt.entry_owner    = cells[rd_idx].entry.owner;
			rsp_nxt.entry_time     = cells[rd_idx].entry.tod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire
